// File: design/glyph_cell_best_match_unit_defines.svh
// Assertion macros used by the glyph cell matcher controller.
`ifndef GLYPH_CELL_BEST_MATCH_UNIT_DEFINES_SVH
`define GLYPH_CELL_BEST_MATCH_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on aclk and disabled during reset.
`define GCBM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and disabled during reset.
`define GCBM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/gcbm_pkg.sv
// Shared constants and controller/datapath interface types for the glyph cell matcher.
package gcbm_pkg;

    localparam int GI_W         = 7;
    localparam int RI_W         = 4;
    localparam int CHAR_BASE    = 32;
    localparam int DRAIN_CYCLES = 3;

    localparam logic [1:0] OP_LOAD_GLYPH = 2'd0;
    localparam logic [1:0] OP_LOAD_CELL  = 2'd1;
    localparam logic [1:0] OP_MATCH      = 2'd2;

    typedef struct packed {
        logic            glyph_wr;
        logic            cell_wr;
        logic            clear;
        logic            rd_en;
        logic            rd_first;
        logic            rd_last;
        logic [GI_W-1:0] rd_glyph;
        logic [RI_W-1:0] rd_row;
        logic            out_load;
    } gcbm_cmd_t;

    typedef struct packed {
        logic perfect;
    } gcbm_status_t;

endpackage

// File: design/gcbm_ctrl.sv
// Controller: transaction handshakes, glyph/row sequencing and result hand-off.
`include "glyph_cell_best_match_unit_defines.svh"

module gcbm_ctrl #(
    parameter int GLYPH_COUNT = 95,
    parameter int CELL_ROWS   = 13
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_opcode,
    input  logic [6:0]             s_glyph_index,
    input  logic [3:0]             s_row_index,
    output logic                   m_valid,
    input  logic                   m_ready,
    output gcbm_pkg::gcbm_cmd_t    cmd,
    input  gcbm_pkg::gcbm_status_t status
);
    import gcbm_pkg::*;

    localparam int DR_W = $clog2(DRAIN_CYCLES);
    localparam logic [DR_W-1:0] DRAIN_LOAD  = DR_W'(DRAIN_CYCLES - 1);
    localparam logic [7:0]      GLYPH_LIM   = 8'(GLYPH_COUNT);
    localparam logic [4:0]      ROW_LIM     = 5'(CELL_ROWS);
    localparam logic [GI_W-1:0] GLYPH_LAST  = GI_W'(GLYPH_COUNT - 1);
    localparam logic [RI_W-1:0] ROW_LAST    = RI_W'(CELL_ROWS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    state_t          state_reg, state_next;
    logic [GI_W-1:0] g_reg, g_next;
    logic [RI_W-1:0] r_reg, r_next;
    logic [DR_W-1:0] drain_reg, drain_next;
    logic            m_valid_reg, m_valid_next;
    logic            accept;
    logic            glyph_in_range;
    logic            row_in_range;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign accept  = s_valid && s_ready;

    assign glyph_in_range = ({1'b0, s_glyph_index} < GLYPH_LIM);
    assign row_in_range   = ({1'b0, s_row_index} < ROW_LIM);

    always_comb begin
        cmd          = '0;
        cmd.glyph_wr = accept && (s_opcode == OP_LOAD_GLYPH) && glyph_in_range && row_in_range;
        cmd.cell_wr  = accept && (s_opcode == OP_LOAD_CELL) && row_in_range;
        cmd.clear    = accept && (s_opcode == OP_MATCH);
        cmd.rd_en    = (state_reg == ST_MATCH);
        cmd.rd_first = (r_reg == '0);
        cmd.rd_last  = (r_reg == ROW_LAST);
        cmd.rd_glyph = g_reg;
        cmd.rd_row   = r_reg;
        // The output register may be refilled once the old result is gone or leaving now.
        cmd.out_load = (state_reg == ST_RESULT) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        state_next   = state_reg;
        g_next       = g_reg;
        r_next       = r_reg;
        drain_next   = drain_reg;
        m_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.clear) begin
                    state_next = ST_MATCH;
                    g_next     = '0;
                    r_next     = '0;
                end
            end
            ST_MATCH: begin
                if (r_reg == ROW_LAST) begin
                    r_next = '0;
                    g_next = g_reg + GI_W'(1);
                end else begin
                    r_next = r_reg + RI_W'(1);
                end
                // A perfect score cannot be beaten, so the scan ends early.
                if (status.perfect || ((r_reg == ROW_LAST) && (g_reg == GLYPH_LAST))) begin
                    state_next = ST_DRAIN;
                    drain_next = DRAIN_LOAD;
                end
            end
            ST_DRAIN: begin
                if (drain_reg == '0) begin
                    state_next = ST_RESULT;
                end else begin
                    drain_next = drain_reg - DR_W'(1);
                end
            end
            ST_RESULT: begin
                if (cmd.out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            g_reg       <= '0;
            r_reg       <= '0;
            drain_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            g_reg       <= g_next;
            r_reg       <= r_next;
            drain_reg   <= drain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `GCBM_ASSERT_IMP(a_no_result_overwrite, m_valid_reg && !m_ready, !cmd.out_load, "result overwritten while pending")
    `GCBM_ASSERT_IMP(a_read_in_range, cmd.rd_en, ({1'b0, cmd.rd_row} < ROW_LIM) && ({1'b0, cmd.rd_glyph} < GLYPH_LIM), "glyph read address out of range")
    `GCBM_ASSERT_NXT(a_match_starts, cmd.clear, (state_reg == ST_MATCH) && (g_reg == '0) && (r_reg == '0), "match did not start from the first glyph")
    `GCBM_ASSERT_IMP(a_no_load_while_busy, state_reg != ST_IDLE, !(cmd.glyph_wr || cmd.cell_wr || cmd.clear), "store written while a match runs")

endmodule

// File: design/gcbm_datapath.sv
// Datapath: glyph memory, cell rows, per-color counters, lane selection and best-match registers.
module gcbm_datapath #(
    parameter int GLYPH_COUNT = 95,
    parameter int CELL_ROWS   = 13
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  gcbm_pkg::gcbm_cmd_t    cmd,
    output gcbm_pkg::gcbm_status_t status,
    input  logic [6:0]             s_glyph_index,
    input  logic [3:0]             s_row_index,
    input  logic [7:0]             s_glyph_bits,
    input  logic [63:0]            s_cell_row,
    output logic [6:0]             m_char_code,
    output logic [2:0]             m_fg_color,
    output logic [2:0]             m_bg_color,
    output logic [6:0]             m_match_score
);
    import gcbm_pkg::*;

    localparam int GA_W     = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int RA_W     = (CELL_ROWS > 1) ? $clog2(CELL_ROWS) : 1;
    localparam int GM_DEPTH = 1 << (GA_W + RA_W);
    localparam int CS_DEPTH = 1 << RA_W;
    localparam int CNT_W    = $clog2(CELL_ROWS * 8 + 1);
    localparam logic [CNT_W-1:0] PERFECT = CNT_W'(CELL_ROWS * 8);

    // Glyph rows: glyph number in the upper address bits, row in the lower ones.
    logic [7:0]            glyph_mem [GM_DEPTH];
    logic [63:0]           cell_store_reg [CS_DEPTH];
    logic [GA_W+RA_W-1:0]  wr_addr;
    logic [GA_W+RA_W-1:0]  rd_addr;

    // Read stage.
    logic [7:0]       glyph_q_reg;
    logic [63:0]      cell_q_reg;
    logic             d1_valid_reg;
    logic             d1_first_reg;
    logic             d1_last_reg;
    logic [GI_W-1:0]  d1_glyph_reg;

    // Accumulate stage.
    logic [7:0]       fg_plane [8];
    logic [7:0]       bg_plane [8];
    logic [CNT_W-1:0] fg_sum [8];
    logic [CNT_W-1:0] bg_sum [8];
    logic [CNT_W-1:0] fg_acc_reg [8];
    logic [CNT_W-1:0] bg_acc_reg [8];
    logic [CNT_W-1:0] fg_tot_reg [8];
    logic [CNT_W-1:0] bg_tot_reg [8];
    logic             tot_valid_reg;
    logic [GI_W-1:0]  tot_glyph_reg;

    // Lane selection stage.
    logic [2:0]       fg_bi;
    logic [2:0]       bg_bi;
    logic [CNT_W-1:0] fg_bv;
    logic [CNT_W-1:0] bg_bv;
    logic             e1_valid_reg;
    logic [GI_W-1:0]  e1_glyph_reg;
    logic [2:0]       fg_idx_reg;
    logic [2:0]       bg_idx_reg;
    logic [CNT_W-1:0] fg_val_reg;
    logic [CNT_W-1:0] bg_val_reg;

    // Best-match stage.
    logic [CNT_W:0]   score;
    logic             take;
    logic             have_reg;
    logic [CNT_W-1:0] top_score_reg;
    logic [GI_W-1:0]  best_glyph_reg;
    logic [2:0]       best_fg_reg;
    logic [2:0]       best_bg_reg;
    logic [CNT_W+6:0] score_ext;

    logic [6:0]       m_char_code_reg;
    logic [2:0]       m_fg_color_reg;
    logic [2:0]       m_bg_color_reg;
    logic [6:0]       m_match_score_reg;

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'b000, v[i]};
        end
        return n;
    endfunction

    assign wr_addr = {s_glyph_index[GA_W-1:0], s_row_index[RA_W-1:0]};
    assign rd_addr = {cmd.rd_glyph[GA_W-1:0], cmd.rd_row[RA_W-1:0]};

    always_ff @(posedge aclk) begin
        if (cmd.glyph_wr) begin
            glyph_mem[wr_addr] <= s_glyph_bits;
        end
        if (cmd.rd_en) begin
            glyph_q_reg <= glyph_mem[rd_addr];
            cell_q_reg  <= cell_store_reg[cmd.rd_row[RA_W-1:0]];
        end
        d1_first_reg <= cmd.rd_first;
        d1_last_reg  <= cmd.rd_last;
        d1_glyph_reg <= cmd.rd_glyph;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CS_DEPTH; i++) begin
                cell_store_reg[i] <= '0;
            end
        end else if (cmd.cell_wr) begin
            cell_store_reg[s_row_index[RA_W-1:0]] <= s_cell_row;
        end
    end

    // Each color plane is counted under the glyph and outside it, one row per cycle.
    always_comb begin
        for (int c = 0; c < 8; c++) begin
            fg_plane[c] = glyph_q_reg & cell_q_reg[8*c +: 8];
            bg_plane[c] = ~glyph_q_reg & cell_q_reg[8*c +: 8];
            fg_sum[c]   = (d1_first_reg ? '0 : fg_acc_reg[c]) + CNT_W'(pop8(fg_plane[c]));
            bg_sum[c]   = (d1_first_reg ? '0 : bg_acc_reg[c]) + CNT_W'(pop8(bg_plane[c]));
        end
    end

    always_ff @(posedge aclk) begin
        if (d1_valid_reg) begin
            for (int c = 0; c < 8; c++) begin
                fg_acc_reg[c] <= fg_sum[c];
                bg_acc_reg[c] <= bg_sum[c];
            end
        end
        if (d1_valid_reg && d1_last_reg) begin
            for (int c = 0; c < 8; c++) begin
                fg_tot_reg[c] <= fg_sum[c];
                bg_tot_reg[c] <= bg_sum[c];
            end
            tot_glyph_reg <= d1_glyph_reg;
        end
    end

    // Largest count per side; a later color must be strictly larger to win.
    always_comb begin
        fg_bi = '0;
        bg_bi = '0;
        fg_bv = fg_tot_reg[0];
        bg_bv = bg_tot_reg[0];
        for (int c = 1; c < 8; c++) begin
            if (fg_tot_reg[c] > fg_bv) begin
                fg_bv = fg_tot_reg[c];
                fg_bi = 3'(c);
            end
            if (bg_tot_reg[c] > bg_bv) begin
                bg_bv = bg_tot_reg[c];
                bg_bi = 3'(c);
            end
        end
    end

    always_ff @(posedge aclk) begin
        e1_glyph_reg <= tot_glyph_reg;
        fg_idx_reg   <= fg_bi;
        bg_idx_reg   <= bg_bi;
        fg_val_reg   <= fg_bv;
        bg_val_reg   <= bg_bv;
    end

    assign score = {1'b0, fg_val_reg} + {1'b0, bg_val_reg};
    assign take  = e1_valid_reg && (!have_reg || (score > {1'b0, top_score_reg}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_valid_reg  <= 1'b0;
            tot_valid_reg <= 1'b0;
            e1_valid_reg  <= 1'b0;
            have_reg      <= 1'b0;
        end else begin
            d1_valid_reg  <= cmd.rd_en;
            tot_valid_reg <= d1_valid_reg && d1_last_reg;
            e1_valid_reg  <= tot_valid_reg;
            if (cmd.clear) begin
                have_reg <= 1'b0;
            end else if (take) begin
                have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            top_score_reg  <= score[CNT_W-1:0];
            best_glyph_reg <= e1_glyph_reg;
            best_fg_reg    <= fg_idx_reg;
            best_bg_reg    <= bg_idx_reg;
        end
    end

    assign status.perfect = have_reg && (top_score_reg == PERFECT);

    assign score_ext = {7'b0000000, top_score_reg};

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_char_code_reg   <= best_glyph_reg + 7'(CHAR_BASE);
            m_fg_color_reg    <= best_fg_reg;
            m_bg_color_reg    <= best_bg_reg;
            m_match_score_reg <= score_ext[6:0];
        end
    end

    assign m_char_code   = m_char_code_reg;
    assign m_fg_color    = m_fg_color_reg;
    assign m_bg_color    = m_bg_color_reg;
    assign m_match_score = m_match_score_reg;

endmodule

// File: design/glyph_cell_best_match_unit.sv
// Glyph cell best-match unit. A match reads one glyph row per cycle from the glyph memory,
// scanning every row of every glyph, then drains the pipeline and hands the result off; the
// scan stops early when a glyph reaches the perfect score. No new transaction is taken while
// a match runs; a finished result waits in the output register while loads go on. The glyph
// memory has no reset and every glyph row a match reads must have been loaded first; the cell
// rows reset to zero.
module glyph_cell_best_match_unit #(
    parameter int GLYPH_COUNT = 95,
    parameter int CELL_ROWS   = 13
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [6:0]  s_glyph_index,
    input  logic [3:0]  s_row_index,
    input  logic [7:0]  s_glyph_bits,
    input  logic [63:0] s_cell_row,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_char_code,
    output logic [2:0]  m_fg_color,
    output logic [2:0]  m_bg_color,
    output logic [6:0]  m_match_score
);
    import gcbm_pkg::*;

    gcbm_cmd_t    cmd;
    gcbm_status_t status;

    gcbm_ctrl #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .CELL_ROWS   (CELL_ROWS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_glyph_index (s_glyph_index),
        .s_row_index   (s_row_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .cmd           (cmd),
        .status        (status)
    );

    gcbm_datapath #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .CELL_ROWS   (CELL_ROWS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_glyph_index (s_glyph_index),
        .s_row_index   (s_row_index),
        .s_glyph_bits  (s_glyph_bits),
        .s_cell_row    (s_cell_row),
        .m_char_code   (m_char_code),
        .m_fg_color    (m_fg_color),
        .m_bg_color    (m_bg_color),
        .m_match_score (m_match_score)
    );

endmodule

// File: dv/glyph_cell_best_match_unit_test.sv
// Self-checking testbench for the glyph cell best-match unit.
module glyph_cell_best_match_unit_test;
    import gcbm_pkg::*;

    localparam int GLYPHS      = 95;
    localparam int ROWS        = 13;
    localparam int RAND_ITEMS  = 480;
    localparam int HOLD_CYCLES = 4000;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 1300;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [6:0]  glyph_index;
        logic [3:0]  row_index;
        logic [7:0]  glyph_bits;
        logic [63:0] cell_row;
    } xact_t;

    typedef struct packed {
        logic [6:0] char_code;
        logic [2:0] fg_color;
        logic [2:0] bg_color;
        logic [6:0] match_score;
    } match_t;

    typedef struct packed {
        xact_t  x;
        logic   typed;
        match_t want;
    } dir_row_t;

    localparam match_t NO_WANT = '0;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [6:0]  s_glyph_index;
    logic [3:0]  s_row_index;
    logic [7:0]  s_glyph_bits;
    logic [63:0] s_cell_row;
    logic        m_valid;
    logic        m_ready;
    logic [6:0]  m_char_code;
    logic [2:0]  m_fg_color;
    logic [2:0]  m_bg_color;
    logic [6:0]  m_match_score;

    // Mirror of the block's glyph memory and cell rows.
    logic [7:0]  font_rows [GLYPHS][ROWS];
    logic [63:0] cell_rows [ROWS];

    match_t   pending_matches[$];
    dir_row_t dir_rows[$];
    int       errors = 0;
    int       src_idle_pct = 10;
    int       snk_idle_pct = 78;
    int       quiet_cycles = 0;
    bit       hold_req = 1'b0;

    glyph_cell_best_match_unit #(
        .GLYPH_COUNT(GLYPHS),
        .CELL_ROWS  (ROWS)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_glyph_index(s_glyph_index),
        .s_row_index  (s_row_index),
        .s_glyph_bits (s_glyph_bits),
        .s_cell_row   (s_cell_row),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_char_code  (m_char_code),
        .m_fg_color   (m_fg_color),
        .m_bg_color   (m_bg_color),
        .m_match_score(m_match_score)
    );

    always #5 aclk = ~aclk;

    function automatic xact_t mk(input logic [1:0] op, input int gi, input int ri,
                                 input int gb, input logic [63:0] cr);
        xact_t x;
        x.opcode      = op;
        x.glyph_index = 7'(gi);
        x.row_index   = 4'(ri);
        x.glyph_bits  = 8'(gb);
        x.cell_row    = cr;
        return x;
    endfunction

    // Updates the mirrored state; returns 1 with the best match when the transaction is a match.
    function automatic bit apply_transaction(input xact_t x, output match_t res);
        int         fg_cnt[8];
        int         bg_cnt[8];
        int         fg, bg, score;
        int         top_score, best_fg, best_bg, best_glyph;
        logic [7:0] plane;
        res = '0;
        case (x.opcode)
            OP_LOAD_GLYPH: begin
                if (x.glyph_index < GLYPHS && x.row_index < ROWS)
                    font_rows[x.glyph_index][x.row_index] = x.glyph_bits;
                return 1'b0;
            end
            OP_LOAD_CELL: begin
                if (x.row_index < ROWS)
                    cell_rows[x.row_index] = x.cell_row;
                return 1'b0;
            end
            OP_MATCH: begin
                top_score  = 0;
                best_fg    = 0;
                best_bg    = 0;
                best_glyph = 0;
                for (int g = 0; g < GLYPHS; g++) begin
                    for (int c = 0; c < 8; c++) begin
                        fg_cnt[c] = 0;
                        bg_cnt[c] = 0;
                    end
                    for (int r = 0; r < ROWS; r++) begin
                        for (int c = 0; c < 8; c++) begin
                            plane = cell_rows[r][8*c +: 8];
                            fg_cnt[c] += $countones(plane & font_rows[g][r]);
                            bg_cnt[c] += $countones(plane & ~font_rows[g][r]);
                        end
                    end
                    fg = 0;
                    bg = 0;
                    for (int c = 1; c < 8; c++) begin
                        if (fg_cnt[c] > fg_cnt[fg]) fg = c;
                        if (bg_cnt[c] > bg_cnt[bg]) bg = c;
                    end
                    score = fg_cnt[fg] + bg_cnt[bg];
                    if (g == 0 || score > top_score) begin
                        top_score  = score;
                        best_fg    = fg;
                        best_bg    = bg;
                        best_glyph = g;
                        if (top_score == ROWS * 8) break;
                    end
                end
                res.char_code   = 7'(CHAR_BASE + best_glyph);
                res.fg_color    = 3'(best_fg);
                res.bg_color    = 3'(best_bg);
                res.match_score = 7'(top_score);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Renders one glyph row in the given foreground and background colors.
    function automatic logic [63:0] paint_row(input logic [7:0] bits, input int fg, input int bg);
        logic [63:0] row;
        row = '0;
        for (int p = 0; p < 8; p++) row[8 * (bits[p] ? fg : bg) + p] = 1'b1;
        return row;
    endfunction

    function automatic logic [63:0] onehot_row();
        logic [63:0] row;
        row = '0;
        for (int p = 0; p < 8; p++) row[8 * $urandom_range(7) + p] = 1'b1;
        return row;
    endfunction

    task automatic offer(input xact_t x, input bit typed, input match_t want);
        match_t got;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= x.opcode;
        s_glyph_index <= x.glyph_index;
        s_row_index   <= x.row_index;
        s_glyph_bits  <= x.glyph_bits;
        s_cell_row    <= x.cell_row;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (apply_transaction(x, got))
            pending_matches.push_back(typed ? want : got);
    endtask

    task automatic add_row(input xact_t x, input bit typed, input match_t want);
        dir_row_t d;
        d.x     = x;
        d.typed = typed;
        d.want  = want;
        dir_rows.push_back(d);
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        match_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_matches.size() == 0) begin
                $display("%0t: result with none pending, expected none, actual char %0d", $time,
                         m_char_code);
                errors++;
            end else begin
                want = pending_matches.pop_front();
                check_field("char_code", want.char_code, m_char_code);
                check_field("fg_color", want.fg_color, m_fg_color);
                check_field("bg_color", want.bg_color, m_bg_color);
                check_field("match_score", want.match_score, m_match_score);
            end
        end
    end

    // Watchdog: a long run of cycles without any transaction means the block hung.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                // Long back-pressure so that finished matches pile up and the input stalls.
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    initial begin
        xact_t       x;
        logic [63:0] row;
        int          rand_items;
        int          pick, g, fg, bg, flip_row, n, phase;

        s_valid       <= 1'b0;
        s_opcode      <= OP_LOAD_GLYPH;
        s_glyph_index <= '0;
        s_row_index   <= '0;
        s_glyph_bits  <= '0;
        s_cell_row    <= '0;
        aresetn       <= 1'b0;
        for (int r = 0; r < ROWS; r++) cell_rows[r] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Every glyph row is written before any match reads it. Glyph 0 is blank and the
        // last glyph is solid, which the directed checks rely on.
        for (int gi = 0; gi < GLYPHS; gi++) begin
            for (int r = 0; r < ROWS; r++) begin
                offer(mk(OP_LOAD_GLYPH, gi, r,
                         gi == 0 ? 0 : (gi == GLYPHS - 1 ? 8'hFF : $urandom_range(255)),
                         {$urandom, $urandom}), 1'b0, NO_WANT);
            end
        end

        add_row(mk(OP_MATCH, 0, 0, 0, '0), 1'b1, {7'd32, 3'd0, 3'd0, 7'd0});
        add_row(mk(OP_LOAD_CELL, 0, 0, 0, 64'hFF00_0000_0000_0000), 1'b0, NO_WANT);
        add_row(mk(OP_MATCH, 0, 0, 0, '0), 1'b1, {7'd32, 3'd0, 3'd7, 7'd8});
        add_row(mk(OP_LOAD_CELL, 127, 13, 255, '1), 1'b0, NO_WANT);
        add_row(mk(OP_LOAD_CELL, 0, 15, 0, '1), 1'b0, NO_WANT);
        add_row(mk(OP_UNUSED, 127, 15, 255, '1), 1'b0, NO_WANT);
        add_row(mk(OP_MATCH, 127, 15, 255, '1), 1'b1, {7'd32, 3'd0, 3'd7, 7'd8});
        add_row(mk(OP_LOAD_GLYPH, 95, 0, 255, '0), 1'b0, NO_WANT);
        add_row(mk(OP_LOAD_GLYPH, 127, 15, 255, '1), 1'b0, NO_WANT);
        add_row(mk(OP_LOAD_GLYPH, 0, 13, 255, '0), 1'b0, NO_WANT);
        add_row(mk(OP_MATCH, 0, 0, 0, '0), 1'b1, {7'd32, 3'd0, 3'd7, 7'd8});
        add_row(mk(OP_LOAD_CELL, 0, 12, 0, 64'h0000_0000_0000_00FF), 1'b0, NO_WANT);
        add_row(mk(OP_LOAD_CELL, 0, 6, 0, '1), 1'b0, NO_WANT);
        add_row(mk(OP_MATCH, 0, 0, 0, '0), 1'b0, NO_WANT);
        add_row(mk(OP_LOAD_GLYPH, GLYPHS - 1, ROWS - 1, 0, '0), 1'b0, NO_WANT);
        add_row(mk(OP_LOAD_GLYPH, 0, 0, 8'h81, '0), 1'b0, NO_WANT);
        add_row(mk(OP_MATCH, 0, 0, 0, '0), 1'b0, NO_WANT);
        add_row(mk(OP_LOAD_CELL, 0, 0, 0, 64'h0000_00FF_0000_0000), 1'b0, NO_WANT);
        add_row(mk(OP_LOAD_CELL, 0, 6, 0, '0), 1'b0, NO_WANT);
        add_row(mk(OP_MATCH, 0, 0, 0, '0), 1'b0, NO_WANT);
        foreach (dir_rows[i]) offer(dir_rows[i].x, dir_rows[i].typed, dir_rows[i].want);

        // Start of the random part: back-pressure while several matches are queued up.
        hold_req = 1'b1;
        for (int i = 0; i < 3; i++) offer(mk(OP_MATCH, 0, 0, 0, '0), 1'b0, NO_WANT);
        rand_items = 3;

        while (rand_items < RAND_ITEMS) begin
            phase = rand_items * 3 / RAND_ITEMS;
            if (phase == 0) begin
                src_idle_pct = 10;
                snk_idle_pct = 78;
            end else if (phase == 1) begin
                src_idle_pct = 78;
                snk_idle_pct = 10;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            pick = $urandom_range(99);
            if (pick < 55) begin
                // Paint a known glyph into the cell, sometimes with one stray pixel.
                g        = $urandom_range(GLYPHS - 1);
                fg       = $urandom_range(7);
                bg       = $urandom_range(7);
                flip_row = ($urandom_range(3) == 0) ? $urandom_range(ROWS - 1) : -1;
                for (int r = 0; r < ROWS; r++) begin
                    row = paint_row(font_rows[g][r], fg, bg);
                    if (r == flip_row) row[$urandom_range(63)] = ~row[$urandom_range(63)];
                    offer(mk(OP_LOAD_CELL, $urandom_range(127), r, $urandom_range(255), row),
                          1'b0, NO_WANT);
                end
                offer(mk(OP_MATCH, $urandom_range(127), $urandom_range(15), $urandom_range(255),
                         {$urandom, $urandom}), 1'b0, NO_WANT);
                rand_items += ROWS + 1;
            end else if (pick < 70) begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(2))
                        0:       row = {$urandom, $urandom};
                        1:       row = onehot_row();
                        default: row = {$urandom, $urandom} & {$urandom, $urandom};
                    endcase
                    offer(mk(OP_LOAD_CELL, $urandom_range(127), $urandom_range(ROWS - 1),
                             $urandom_range(255), row), 1'b0, NO_WANT);
                end
                offer(mk(OP_MATCH, 0, 0, 0, '0), 1'b0, NO_WANT);
                rand_items += n + 1;
            end else if (pick < 82) begin
                offer(mk(OP_LOAD_GLYPH, $urandom_range(GLYPHS - 1), $urandom_range(ROWS - 1),
                         $urandom_range(255), {$urandom, $urandom}), 1'b0, NO_WANT);
                rand_items++;
            end else if (pick < 90) begin
                offer(mk(OP_MATCH, $urandom_range(127), $urandom_range(15), $urandom_range(255),
                         {$urandom, $urandom}), 1'b0, NO_WANT);
                rand_items++;
            end else begin
                // Transactions the block ignores; they do not count toward the item budget.
                case ($urandom_range(3))
                    0: x = mk(OP_LOAD_GLYPH, $urandom_range(GLYPHS, 127), $urandom_range(15),
                              $urandom_range(255), {$urandom, $urandom});
                    1: x = mk(OP_LOAD_GLYPH, $urandom_range(127), $urandom_range(ROWS, 15),
                              $urandom_range(255), {$urandom, $urandom});
                    2: x = mk(OP_LOAD_CELL, $urandom_range(127), $urandom_range(ROWS, 15),
                              $urandom_range(255), {$urandom, $urandom});
                    default: x = mk(OP_UNUSED, $urandom_range(127), $urandom_range(15),
                                    $urandom_range(255), {$urandom, $urandom});
                endcase
                offer(x, 1'b0, NO_WANT);
            end
        end
        s_valid <= 1'b0;

        while (pending_matches.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/gcbm_pkg.sv
design/gcbm_ctrl.sv
design/gcbm_datapath.sv
design/glyph_cell_best_match_unit.sv
dv/glyph_cell_best_match_unit_test.sv
